>>> src/gwtd_pkg.sv
// ----------------------------------------------------------------------------
// gwtd_pkg
// Shared types and constants for the gyro window turn detector.
// ----------------------------------------------------------------------------
package gwtd_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned THRESH_W = 15;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned LEG_W    = 16;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd2000;
	localparam logic [LEG_W-1:0]    LEG_MAX      = 16'hFFFF;
	localparam logic [LEG_W-1:0]    LEG_FIRST    = 16'd1;

	// window occupancy after the current sample has been pushed
	typedef struct packed {
		logic full;
		logic empty;
	} win_status_t;

	// turn and leg state, also the visible result
	typedef struct packed {
		logic              turning;
		logic [LEG_W-1:0]  leg_number;
		logic              on_short_leg;
		logic [TIME_W-1:0] leg_start_ms;
	} leg_state_t;

endpackage

>>> src/gwtd_window.sv
// ----------------------------------------------------------------------------
// gwtd_window
// Sliding window of threshold flags with a running count of set flags.
// ----------------------------------------------------------------------------
module gwtd_window #(
	parameter int unsigned WINDOW = 30
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic signed [gwtd_pkg::SAMPLE_W-1:0] sample,
	input  logic [gwtd_pkg::THRESH_W-1:0]   threshold,
	output gwtd_pkg::win_status_t           status
);
	import gwtd_pkg::*;

	localparam int unsigned CW = $clog2(WINDOW + 1);

	logic [WINDOW-1:0]   flags_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_next;
	logic [SAMPLE_W-1:0] mag;
	logic                flag;
	logic                oldest;

	// two's complement magnitude, -32768 maps to 32768
	assign mag    = sample[SAMPLE_W-1] ? SAMPLE_W'(~sample + 1'b1) : SAMPLE_W'(sample);
	assign flag   = mag > {1'b0, threshold};
	assign oldest = flags_q[WINDOW-1];

	assign count_next   = count_q + CW'(flag) - CW'(oldest);
	assign status.full  = count_next == CW'(WINDOW);
	assign status.empty = count_next == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			count_q <= '0;
		end else if (step) begin
			flags_q <= {flags_q[WINDOW-2:0], flag};
			count_q <= count_next;
		end
	end

endmodule

>>> src/gwtd_leg.sv
// ----------------------------------------------------------------------------
// gwtd_leg
// Turn hysteresis and flight leg tracking; the state doubles as the result.
// ----------------------------------------------------------------------------
module gwtd_leg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  gwtd_pkg::win_status_t         status,
	input  logic [gwtd_pkg::TIME_W-1:0]   now,
	output gwtd_pkg::leg_state_t          state
);
	import gwtd_pkg::*;

	leg_state_t state_q;
	leg_state_t state_next;

	always_comb begin
		state_next = state_q;
		if (state_q.turning) begin
			if (status.empty) begin
				state_next.turning = 1'b0;
			end
		end else if (status.full) begin
			state_next.turning = 1'b1;
			if (!state_q.on_short_leg) begin
				state_next.on_short_leg = 1'b1;
			end else begin
				state_next.on_short_leg = 1'b0;
				if (state_q.leg_number != LEG_MAX) begin
					state_next.leg_number = state_q.leg_number + 1'b1;
				end
				state_next.leg_start_ms = now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.turning      <= 1'b0;
			state_q.leg_number   <= LEG_FIRST;
			state_q.on_short_leg <= 1'b0;
			state_q.leg_start_ms <= '0;
		end else if (step) begin
			state_q <= state_next;
		end
	end

	assign state = state_q;

endmodule

>>> src/gyro_window_turn_detector.sv
// ----------------------------------------------------------------------------
// gyro_window_turn_detector
// Turn detector over a sliding window of gyro rate samples, with leg tracking.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid / in_stall carry one request of rate_sample and
//                    now_ms; accepted on a clock edge with in_valid high and
//                    in_stall low
//   output channel : out_valid / out_stall carry one result per request
//                    (turning, leg_number, on_short_leg, leg_start_ms),
//                    showing the state after that sample
//   config         : cfg_wr_en / cfg_wr_data write rate_threshold; the user
//                    must write only while the block is idle; not enforced
//   path           : an accepted request passes the input register, then
//                    the state/result register, whose load raises out_valid
//   throughput     : 1 request per cycle without stalls; the window count
//                    is updated incrementally, one add and compare per sample
//   reset          : window cleared, leg 1 long, threshold 2000, no result
//   stall          : a stalled result holds; one more request waits in the
//                    input register, after which in_stall rises
// ----------------------------------------------------------------------------
module gyro_window_turn_detector #(
	parameter int unsigned WINDOW = 30
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [gwtd_pkg::THRESH_W-1:0]         cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [gwtd_pkg::SAMPLE_W-1:0]  rate_sample,
	input  logic [gwtd_pkg::TIME_W-1:0]           now_ms,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  turning,
	output logic [gwtd_pkg::LEG_W-1:0]            leg_number,
	output logic                                  on_short_leg,
	output logic [gwtd_pkg::TIME_W-1:0]           leg_start_ms
);
	import gwtd_pkg::*;

	logic [THRESH_W-1:0]        thresh_q;
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [TIME_W-1:0]          now_s1;
	logic                       valid_s2;
	logic                       step;
	logic                       load_s1;
	win_status_t                status;
	leg_state_t                 state;

	// state advances only when the result stage is free or drains
	assign step     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			sample_s1 <= rate_sample;
			now_s1    <= now_ms;
		end
	end

	gwtd_window #(
		.WINDOW(WINDOW)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.sample   (sample_s1),
		.threshold(thresh_q),
		.status   (status)
	);

	gwtd_leg u_leg (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.status(status),
		.now   (now_s1),
		.state (state)
	);

	assign out_valid    = valid_s2;
	assign turning      = state.turning;
	assign leg_number   = state.leg_number;
	assign on_short_leg = state.on_short_leg;
	assign leg_start_ms = state.leg_start_ms;

endmodule

>>> src/gwtd_checker.sv
// ----------------------------------------------------------------------------
// gwtd_checker
// Port-level checks for the gyro window turn detector, bound to the top level.
// ----------------------------------------------------------------------------
module gwtd_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [gwtd_pkg::LEG_W-1:0]    leg_number,
	input  logic                          on_short_leg,
	input  logic [gwtd_pkg::TIME_W-1:0]   leg_start_ms
);
	import gwtd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(leg_number)
			&& $stable(on_short_leg) && $stable(leg_start_ms))
		else $error("stalled result changed");

	// input only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_leg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> leg_number != '0)
		else $error("leg number zero");

	// the first long leg is never entered by a turn, so no time is latched
	a_first_leg_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !on_short_leg && leg_number == LEG_FIRST |-> leg_start_ms == '0)
		else $error("time latched on first long leg");

endmodule

bind gyro_window_turn_detector gwtd_checker u_gwtd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.leg_number  (leg_number),
	.on_short_leg(on_short_leg),
	.leg_start_ms(leg_start_ms)
);

>>> bench/tb_gyro_window_turn_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gyro_window_turn_detector
// Self-checking bench for the gyro window turn detector. A behavioral copy of
// the window, turn and leg logic predicts one result per accepted request.
// Results are compared field by field while both channels idle and stall at
// random, across several threshold settings.
// ----------------------------------------------------------------------------
module tb_gyro_window_turn_detector;
	import gwtd_pkg::*;

	localparam int WIN_LEN         = 30;
	localparam int DRAIN_CYCLES    = 4;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 2000;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_WAVE} stall_mode_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_wr_en   = 1'b0;
	logic [THRESH_W-1:0]        cfg_wr_data = '0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] rate_sample = '0;
	logic [TIME_W-1:0]          now_ms      = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic                       turning;
	logic [LEG_W-1:0]           leg_number;
	logic                       on_short_leg;
	logic [TIME_W-1:0]          leg_start_ms;

	gyro_window_turn_detector #(.WINDOW(WIN_LEN)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rate_sample  (rate_sample),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.turning      (turning),
		.leg_number   (leg_number),
		.on_short_leg (on_short_leg),
		.leg_start_ms (leg_start_ms)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted detector state
	bit                  turn_flags [WIN_LEN];
	int                  flag_total     = 0;
	int                  flag_slot      = 0;
	logic                in_turn_now    = 1'b0;
	logic [LEG_W-1:0]    leg_now        = LEG_FIRST;
	logic                short_leg_now  = 1'b0;
	logic [TIME_W-1:0]   leg_time_now   = '0;
	logic [THRESH_W-1:0] threshold_now  = THRESH_RESET;

	leg_state_t          pending_legs [$];
	leg_state_t          want_leg;

	int                  samples_sent       = 0;
	int                  results_checked    = 0;
	int                  turn_starts        = 0;
	int                  thresholds_written = 0;
	int                  mismatches         = 0;
	int                  burst_left         = 0;
	int                  idle_cycles        = 0;
	logic [TIME_W-1:0]   clock_ms           = '0;

	stall_mode_t         stall_mode  = STALL_NONE;
	int                  stall_hold  = 0;
	logic [1:0]          stall_phase = '0;

	function automatic leg_state_t advance_legs(input logic signed [SAMPLE_W-1:0] sample,
			input logic [TIME_W-1:0] stamp);
		int         mag;
		bit         hit;
		leg_state_t res;
		mag = (sample < 0) ? -int'(sample) : int'(sample);
		hit = (mag > int'(threshold_now));
		flag_total -= int'(turn_flags[flag_slot]);
		turn_flags[flag_slot] = hit;
		flag_total += int'(hit);
		flag_slot = (flag_slot + 1) % WIN_LEN;
		if (in_turn_now) begin
			if (flag_total == 0)
				in_turn_now = 1'b0;
		end else if (flag_total == WIN_LEN) begin
			in_turn_now = 1'b1;
			turn_starts++;
			if (!short_leg_now) begin
				short_leg_now = 1'b1;
			end else begin
				// a long leg begins: count up and latch the sample time
				short_leg_now = 1'b0;
				if (leg_now != LEG_MAX)
					leg_now++;
				leg_time_now = stamp;
			end
		end
		res.turning      = in_turn_now;
		res.leg_number   = leg_now;
		res.on_short_leg = short_leg_now;
		res.leg_start_ms = leg_time_now;
		return res;
	endfunction

	// sample above or at/below the current threshold, boundary values favored
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit over);
		int mag;
		if (over)
			mag = ($urandom_range(0, 7) == 0) ? int'(threshold_now) + 1
				: $urandom_range(32768, int'(threshold_now) + 1);
		else
			mag = ($urandom_range(0, 7) == 0) ? int'(threshold_now)
				: $urandom_range(int'(threshold_now), 0);
		if (mag == 32768 || (mag != 0 && $urandom_range(0, 1) == 1))
			return SAMPLE_W'(-mag);
		return SAMPLE_W'(mag);
	endfunction

	function automatic logic [TIME_W-1:0] next_stamp();
		if ($urandom_range(0, 49) == 0)
			clock_ms = $urandom();
		else
			clock_ms += $urandom_range(1, 40);
		return clock_ms;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// one request; valid stays up into the next request unless a gap follows
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample,
			input logic [TIME_W-1:0] stamp);
		int gap;
		in_valid    <= 1'b1;
		rate_sample <= sample;
		now_ms      <= stamp;
		do @(posedge clk); while (in_stall);
		pending_legs.push_back(advance_legs(sample, stamp));
		samples_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 20);
		end
	endtask

	task automatic write_threshold(input logic [THRESH_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_legs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		threshold_now  = value;
		thresholds_written++;
	endtask

	// extremes of both fields at the reset threshold; too few turning samples
	// to fill the window, so no turn may start
	task automatic test_field_extremes();
		send_sample(16'sd0, 32'h0000_0000);
		send_sample(16'sd32767, 32'hFFFF_FFFF);
		send_sample(-16'sd32768, 32'h0000_0001);
		send_sample(-16'sd1, 32'h8000_0000);
		send_sample(16'sd1, 32'h7FFF_FFFF);
		send_sample(16'sd2000, 32'h5555_5555);
		send_sample(16'sd2001, 32'hAAAA_AAAA);
		send_sample(-16'sd2000, 32'h0000_FFFF);
		send_sample(-16'sd2001, 32'hFFFF_0000);
		repeat (10) send_sample(16'sd32767, $urandom());
	endtask

	task automatic test_threshold_extremes();
		write_threshold('0);
		send_sample(16'sd0, $urandom());
		send_sample(16'sd1, $urandom());
		send_sample(-16'sd1, $urandom());
		write_threshold({THRESH_W{1'b1}});
		send_sample(16'sd32767, $urandom());
		send_sample(-16'sd32768, $urandom());
	endtask

	// alternating turning and quiet runs; most fill the window, some fall short
	task automatic test_turn_legs();
		logic [THRESH_W-1:0] sweep [5];
		bit over;
		int len;
		sweep[0] = THRESH_RESET;
		sweep[1] = THRESH_W'($urandom_range(1, 32766));
		sweep[2] = '0;
		sweep[3] = {THRESH_W{1'b1}};
		sweep[4] = THRESH_W'($urandom_range(100, 4000));
		clock_ms = $urandom();
		foreach (sweep[p]) begin
			write_threshold(sweep[p]);
			over = 1'b1;
			repeat (6) begin
				len = ($urandom_range(0, 9) != 0) ? WIN_LEN + $urandom_range(0, 12)
					: $urandom_range(1, WIN_LEN - 1);
				repeat (len) send_sample(pick_sample(over), next_stamp());
				over = !over;
			end
		end
	endtask

	task automatic test_random_noise();
		repeat (150) send_sample(SAMPLE_W'($urandom()), $urandom());
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_legs.size() == 0) begin
				note_mismatch("result with no request outstanding");
			end else begin
				want_leg = pending_legs.pop_front();
				if (turning !== want_leg.turning)
					note_mismatch($sformatf("result %0d turning %b, want %b",
						results_checked, turning, want_leg.turning));
				if (leg_number !== want_leg.leg_number)
					note_mismatch($sformatf("result %0d leg_number %0d, want %0d",
						results_checked, leg_number, want_leg.leg_number));
				if (on_short_leg !== want_leg.on_short_leg)
					note_mismatch($sformatf("result %0d on_short_leg %b, want %b",
						results_checked, on_short_leg, want_leg.on_short_leg));
				if (leg_start_ms !== want_leg.leg_start_ms)
					note_mismatch($sformatf("result %0d leg_start_ms %h, want %h",
						results_checked, leg_start_ms, want_leg.leg_start_ms));
			end
			results_checked++;
		end
	end

	// receiver backpressure: modes held for random stretches
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_hold <= $urandom_range(20, 150);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		stall_phase <= stall_phase + 1'b1;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= stall_phase[1];
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_threshold_extremes();
		test_turn_legs();
		test_random_noise();
		in_valid <= 1'b0;
		while (pending_legs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d samples and %0d results over %0d threshold writes",
			samples_sent, results_checked, thresholds_written);
		$display("%0d turns started, last leg %0d, %0d mismatches",
			turn_starts, leg_now, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
src/gwtd_pkg.sv
src/gwtd_window.sv
src/gwtd_leg.sv
src/gyro_window_turn_detector.sv
src/gwtd_checker.sv
bench/tb_gyro_window_turn_detector.sv
